>>> rtl/gated_pulse_generator_with_resume_unit_defines.svh
// Assertion macros shared by the gated pulse generator RTL.
// No dependencies; included by the files that carry assertions.
`ifndef GATED_PULSE_GENERATOR_WITH_RESUME_UNIT_DEFINES_SVH
`define GATED_PULSE_GENERATOR_WITH_RESUME_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define GPG_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("gated pulse generator check failed");
`define GPG_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("gated pulse generator forbidden condition");
`else
`define GPG_ASSERT(label, clk, rst_n, prop)
`define GPG_ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

>>> rtl/gpg_pkg.sv
// Types and constants of the gated pulse generator.
// No dependencies; used by the interfaces, the core and the top level.
`default_nettype none

package gpg_pkg;

    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_STATUS = 1'b1;

    typedef enum logic [1:0] {
        MODE_STOPPED = 2'd0,
        MODE_STARTED = 2'd1,
        MODE_ARMED   = 2'd2,
        MODE_GATED   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        EVT_NONE    = 2'd0,
        EVT_STARTED = 2'd1,
        EVT_STOPPED = 2'd2
    } t_event;

    typedef struct packed {
        logic        operation;
        logic        gate_open;
        t_mode       new_mode;
        logic [31:0] cycle_ms;
    } t_in_item;

    typedef struct packed {
        logic        pin_level;
        logic [31:0] pulse_total;
        t_event      event_code;
        t_mode       mode_now;
    } t_out_item;

endpackage

`default_nettype wire

>>> rtl/gpg_if.sv
// Valid/ready stream interfaces for the input items and the result items.
// Depends on gpg_pkg for the payload types.
`default_nettype none

interface gpg_in_if;
    import gpg_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface gpg_out_if;
    import gpg_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/gated_pulse_generator_with_resume_unit.sv
// Top level of the gated square-wave pulse generator with mid-cycle resume.
// Depends on gpg_pkg, gpg_if, gpg_core and the assertion macro header.
//
// Usage:
//   i_in carries one item per transfer: a one millisecond tick with a gate
//   sample, or a status command that sets the mode and the cycle time.
//   o_out carries exactly one result per item: pin level, rising edge count,
//   gated start/stop event and the mode after the item.
// Path: an item sits in the input register, and the state update then loads
//   its result into the result register, from which it is offered.
// Throughput: one item per cycle while o_out is not stalled; the whole
//   state update is one pass of compare, add and subtract logic between
//   the two registers.
// Reset: synchronous, active low; clears the mode to stopped, the counters
//   and the resume record, sets the half period to all ones and empties
//   both registers.
// Stall: while the receiver holds o_out.ready low the result is held, and
//   the input register still takes one more item before i_in.ready falls.
`default_nettype none
`include "gated_pulse_generator_with_resume_unit_defines.svh"

module gated_pulse_generator_with_resume_unit (
    input wire        i_clk,
    input wire        i_rst_n,
    gpg_in_if.sink    i_in,
    gpg_out_if.source o_out
);
    import gpg_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item result;
    logic      advance;
    logic      fire;

    assign advance    = !r_out_valid || o_out.ready;
    assign fire       = r_in_valid && advance;
    assign i_in.ready = !r_in_valid || advance;

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    gpg_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.payload;
        end
        if (fire) begin
            r_out <= result;
        end
    end

    `GPG_ASSERT(a_start_enters_gated, i_clk, i_rst_n, o_out.valid && (o_out.payload.event_code == EVT_STARTED) |-> (o_out.payload.mode_now == MODE_GATED))
    `GPG_ASSERT(a_stop_enters_armed, i_clk, i_rst_n, o_out.valid && (o_out.payload.event_code == EVT_STOPPED) |-> (o_out.payload.mode_now == MODE_ARMED) && !o_out.payload.pin_level)
    `GPG_ASSERT(a_full_blocks_input, i_clk, i_rst_n, r_in_valid && r_out_valid && !o_out.ready |-> !i_in.ready)
    `GPG_ASSERT_NEVER(a_no_fire_when_empty, i_clk, i_rst_n, fire && !r_in_valid)

endmodule

`default_nettype wire

>>> rtl/gpg_core.sv
// Generator state and its next-state logic for one tick or status command.
// Depends on gpg_pkg; instantiated by the top level.
`default_nettype none

module gpg_core (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_fire,
    input  gpg_pkg::t_in_item  i_item,
    output gpg_pkg::t_out_item o_result
);
    import gpg_pkg::*;

    typedef struct packed {
        t_mode       mode;
        logic [31:0] cycle_length;
        logic [31:0] half_period;
        logic [31:0] elapsed;
        logic        level;
        logic [31:0] edge_count;
        logic        saved_level;
        logic [31:0] remaining;
        logic        resume_valid;
    } t_state;

    function automatic logic is_running(t_mode m);
        return (m == MODE_STARTED) || (m == MODE_GATED);
    endfunction

    function automatic t_state apply_status(t_state s, t_mode want, logic [31:0] cyc);
        t_state      r;
        logic [31:0] new_half;
        logic        changed;
        r        = s;
        new_half = (cyc != 32'd0) ? {1'b0, cyc[31:1]} : ALL_ONES;
        changed  = (s.cycle_length != cyc);
        if (s.mode != want) begin
            if (is_running(s.mode)) begin
                r.saved_level  = s.level;
                r.remaining    = (s.elapsed < s.half_period) ?
                                 (s.half_period - s.elapsed) : 32'd0;
                r.resume_valid = 1'b1;
            end
            r.mode = want;
            if (is_running(want) && r.resume_valid && (r.remaining != 32'd0) && !changed) begin
                r.level     = r.saved_level;
                r.elapsed   = new_half - r.remaining;
                r.remaining = 32'd0;
            end else begin
                r.level   = 1'b0;
                r.elapsed = 32'd0;
            end
        end else if (changed) begin
            r.elapsed = 32'd0;
        end
        if (cyc != 32'd0) begin
            r.cycle_length = cyc;
            r.half_period  = new_half;
        end
        return r;
    endfunction

    function automatic t_state run_timer(t_state s);
        t_state r;
        r = s;
        if (s.elapsed >= s.half_period) begin
            r.elapsed = s.elapsed - s.half_period;
            r.level   = ~s.level;
            if (r.level) begin
                r.edge_count = s.edge_count + 32'd1;
            end
        end
        return r;
    endfunction

    t_state      r_state;
    t_state      n_state;
    t_state      s_inc;
    t_state      s_base;
    t_state      s_status;
    t_state      s_timer;
    t_mode       want_sel;
    logic [31:0] cyc_sel;
    logic        is_tick;
    logic        gate_start;
    logic        gate_stop;
    t_event      evt;

    always_comb begin
        is_tick    = (i_item.operation == OP_TICK);
        gate_start = is_tick && (r_state.mode == MODE_ARMED) && i_item.gate_open;
        gate_stop  = is_tick && (r_state.mode == MODE_GATED) && !i_item.gate_open;

        s_inc = r_state;
        if (r_state.elapsed != ALL_ONES) begin
            s_inc.elapsed = r_state.elapsed + 32'd1;
        end

        s_base   = is_tick ? s_inc : r_state;
        want_sel = !is_tick ? i_item.new_mode : (gate_start ? MODE_GATED : MODE_ARMED);
        cyc_sel  = is_tick ? r_state.cycle_length : i_item.cycle_ms;
        s_status = apply_status(s_base, want_sel, cyc_sel);
        s_timer  = run_timer(s_inc);

        if (!is_tick || gate_start || gate_stop) begin
            n_state = s_status;
        end else if (is_running(r_state.mode)) begin
            n_state = s_timer;
        end else begin
            n_state = s_inc;
        end

        if (gate_start) begin
            evt = EVT_STARTED;
        end else if (gate_stop) begin
            evt = EVT_STOPPED;
        end else begin
            evt = EVT_NONE;
        end

        o_result.pin_level   = n_state.level;
        o_result.pulse_total = n_state.edge_count;
        o_result.event_code  = evt;
        o_result.mode_now    = n_state.mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode         <= MODE_STOPPED;
            r_state.cycle_length <= 32'd0;
            r_state.half_period  <= ALL_ONES;
            r_state.elapsed      <= 32'd0;
            r_state.level        <= 1'b0;
            r_state.edge_count   <= 32'd0;
            r_state.saved_level  <= 1'b0;
            r_state.remaining    <= 32'd0;
            r_state.resume_valid <= 1'b0;
        end else if (i_fire) begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for the gated pulse generator with mid-cycle resume.
// Depends on gpg_pkg and the gpg_in_if/gpg_out_if interfaces; drives ticks and status
// commands, predicts every result in place and checks each transfer on the result side.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gpg_pkg::*;

    localparam int CYCLE_LIMIT  = 200_000;
    localparam int RANDOM_ITEMS = 1300;
    localparam int MAX_REPORTS  = 10;

    logic i_clk = 1'b0;
    logic i_rst_n;

    gpg_in_if  in_if();
    gpg_out_if out_if();

    gated_pulse_generator_with_resume_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_mode       pg_mode        = MODE_STOPPED;
    logic [31:0] pg_cycle       = 32'd0;
    logic [31:0] pg_half        = ALL_ONES;
    logic [31:0] pg_elapsed     = 32'd0;
    logic        pg_level       = 1'b0;
    logic [31:0] pg_edges       = 32'd0;
    logic        pg_saved_level = 1'b0;
    logic [31:0] pg_remaining   = 32'd0;
    logic        pg_resume_ok   = 1'b0;

    t_out_item pulse_expect_q[$];
    t_out_item got_item;
    t_out_item want_item;

    bit steady_flow = 1'b0;
    int error_count = 0;
    int cycle_count = 0;
    int tick_count = 0;
    int status_count = 0;
    int result_count = 0;
    int gated_starts = 0;
    int gated_stops = 0;

    function automatic bit is_running_mode(t_mode m);
        return m == MODE_STARTED || m == MODE_GATED;
    endfunction

    function automatic void set_status(t_mode want, logic [31:0] cyc);
        logic [31:0] new_half;
        logic        changed;
        new_half = (cyc != 32'd0) ? (cyc >> 1) : ALL_ONES;
        changed = (pg_cycle != cyc);
        if (pg_mode != want) begin
            if (is_running_mode(pg_mode)) begin
                pg_saved_level = pg_level;
                pg_remaining = (pg_elapsed < pg_half) ? pg_half - pg_elapsed : 32'd0;
                pg_resume_ok = 1'b1;
            end
            pg_mode = want;
            if (is_running_mode(want) && pg_resume_ok && pg_remaining != 32'd0 && !changed) begin
                pg_level = pg_saved_level;
                pg_elapsed = new_half - pg_remaining;
                pg_remaining = 32'd0;
            end else begin
                pg_level = 1'b0;
                pg_elapsed = 32'd0;
            end
        end else if (changed) begin
            pg_elapsed = 32'd0;
        end
        if (cyc != 32'd0) begin
            pg_cycle = cyc;
            pg_half = new_half;
        end
    endfunction

    function automatic void advance_phase();
        if (pg_elapsed >= pg_half) begin
            pg_elapsed = pg_elapsed - pg_half;
            pg_level = ~pg_level;
            if (pg_level) begin
                pg_edges = pg_edges + 32'd1;
            end
        end
    endfunction

    function automatic t_out_item predict_pulse(t_in_item it);
        t_out_item r;
        t_event    evt;
        evt = EVT_NONE;
        if (it.operation == OP_STATUS) begin
            set_status(it.new_mode, it.cycle_ms);
        end else begin
            if (pg_elapsed != ALL_ONES) begin
                pg_elapsed = pg_elapsed + 32'd1;
            end
            case (pg_mode)
                MODE_STARTED: begin
                    advance_phase();
                end
                MODE_ARMED: begin
                    if (it.gate_open) begin
                        set_status(MODE_GATED, pg_cycle);
                        evt = EVT_STARTED;
                    end
                end
                MODE_GATED: begin
                    if (!it.gate_open) begin
                        set_status(MODE_ARMED, pg_cycle);
                        evt = EVT_STOPPED;
                    end else begin
                        advance_phase();
                    end
                end
                default: begin
                end
            endcase
        end
        r.pin_level = pg_level;
        r.pulse_total = pg_edges;
        r.event_code = evt;
        r.mode_now = pg_mode;
        return r;
    endfunction

    task automatic send_item(t_in_item it);
        @(negedge i_clk);
        while (!steady_flow && $urandom_range(99) < 23) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.payload <= it;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        pulse_expect_q.push_back(predict_pulse(it));
        if (it.operation == OP_STATUS) begin
            status_count++;
        end else begin
            tick_count++;
        end
    endtask

    task automatic tick(logic gate);
        t_in_item it;
        it.operation = OP_TICK;
        it.gate_open = gate;
        it.new_mode = t_mode'($urandom_range(3));
        it.cycle_ms = $urandom;
        send_item(it);
    endtask

    task automatic command(t_mode m, logic [31:0] cyc);
        t_in_item it;
        it.operation = OP_STATUS;
        it.gate_open = 1'($urandom_range(1));
        it.new_mode = m;
        it.cycle_ms = cyc;
        send_item(it);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (pulse_expect_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_stopped();
        tick(1'b0);
        tick(1'b1);
        command(MODE_STOPPED, 32'd0);
        command(MODE_STOPPED, ALL_ONES);
    endtask

    task automatic test_free_running();
        command(MODE_STARTED, 32'd1);
        tick(1'b0);
        tick(1'b1);
        tick(1'b0);
        command(MODE_STARTED, 32'd0);
        tick(1'b1);
        command(MODE_STARTED, ALL_ONES);
        tick(1'b0);
    endtask

    task automatic test_resume();
        command(MODE_STOPPED, 32'd8);
        command(MODE_STARTED, 32'd9);
        tick(1'b0);
        // Leaving with three milliseconds left, then returning with a half period of two,
        // puts the elapsed time at all ones so the next tick has to saturate.
        command(MODE_STOPPED, 32'd4);
        command(MODE_STARTED, 32'd4);
        tick(1'b0);
        tick(1'b0);
        command(MODE_STOPPED, 32'd4);
        command(MODE_STARTED, 32'd4);
        tick(1'b1);
        wait_drained();
    endtask

    task automatic test_gated();
        command(MODE_ARMED, 32'd4);
        tick(1'b0);
        tick(1'b1);
        tick(1'b1);
        tick(1'b1);
        tick(1'b0);
        command(MODE_GATED, 32'd4);
        tick(1'b1);
        command(MODE_STOPPED, 32'd0);
    endtask

    task automatic test_random();
        t_in_item    it;
        logic        gate;
        int unsigned pick;
        gate = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady_flow = (n >= 500 && n < 700);
            if (n == 900) begin
                wait_drained();
            end
            if ($urandom_range(99) < 15) begin
                gate = ~gate;
            end
            it.gate_open = gate;
            it.new_mode = t_mode'($urandom_range(3));
            pick = $urandom_range(99);
            if (pick < 30) begin
                it.cycle_ms = pg_cycle;
            end else if (pick < 40) begin
                it.cycle_ms = 32'd0;
            end else if (pick < 75) begin
                it.cycle_ms = $urandom_range(16, 1);
            end else if (pick < 85) begin
                it.cycle_ms = $urandom_range(300, 17);
            end else if (pick < 95) begin
                it.cycle_ms = $urandom;
            end else begin
                it.cycle_ms = ALL_ONES - $urandom_range(3);
            end
            it.operation = ($urandom_range(99) < 15) ? OP_STATUS : OP_TICK;
            send_item(it);
        end
        steady_flow = 1'b0;
    endtask

    always @(negedge i_clk) begin
        out_if.ready <= steady_flow || ($urandom_range(99) >= 23);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            got_item = out_if.payload;
            result_count++;
            if (got_item.event_code == EVT_STARTED) begin
                gated_starts++;
            end else if (got_item.event_code == EVT_STOPPED) begin
                gated_stops++;
            end
            if (pulse_expect_q.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS) begin
                    $display("Unexpected result transfer: level %0b total %0d event %0d mode %0d",
                             got_item.pin_level, got_item.pulse_total,
                             got_item.event_code, got_item.mode_now);
                end
            end else begin
                want_item = pulse_expect_q.pop_front();
                if (got_item.pin_level !== want_item.pin_level ||
                    got_item.pulse_total !== want_item.pulse_total ||
                    got_item.event_code !== want_item.event_code ||
                    got_item.mode_now !== want_item.mode_now) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("Mismatch on result %0d: expected level %0b total %0d",
                                 result_count, want_item.pin_level, want_item.pulse_total,
                                 " event %0d mode %0d,",
                                 want_item.event_code, want_item.mode_now,
                                 " got level %0b total %0d event %0d mode %0d",
                                 got_item.pin_level, got_item.pulse_total,
                                 got_item.event_code, got_item.mode_now);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run timed out after %0d cycles with %0d results outstanding",
                     cycle_count, pulse_expect_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.payload = '0;
        out_if.ready = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_stopped();
        test_free_running();
        test_resume();
        test_gated();
        test_random();

        wait_drained();
        repeat (6) @(posedge i_clk);

        $display("Sent %0d ticks and %0d status commands, checked %0d results.",
                 tick_count, status_count, result_count);
        $display("Saw %0d gated starts and %0d gated stops, final edge count %0d, %0d mismatches.",
                 gated_starts, gated_stops, pg_edges, error_count);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
+incdir+rtl
rtl/gpg_pkg.sv
rtl/gpg_if.sv
rtl/gpg_core.sv
rtl/gated_pulse_generator_with_resume_unit.sv
verif/testbench.sv
